[hw/rtl/lmbc_pkg.sv]
// Shared constants, request codes, register indexes and glyph lookup for the
// LED matrix blink controller. No dependencies.
`default_nettype none

package lmbc_pkg;

  // Default geometry
  localparam int ROW_COUNT_DEF   = 8;
  localparam int COL_COUNT_DEF   = 32;
  localparam int CLASS_COUNT_DEF = 2;

  // Field widths
  localparam int REQ_W      = 4;
  localparam int FIELD_W    = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;
  localparam int PIX_W      = 32;
  localparam int SEL_W      = 8;
  localparam int TIME_W     = 15;
  localparam int OFFSET_W   = 14;
  localparam int GIDX_W     = 5;
  localparam int ELAPSED_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK            = 4'd0;
  localparam logic [REQ_W-1:0] REQ_SCAN            = 4'd1;
  localparam logic [REQ_W-1:0] REQ_ON              = 4'd2;
  localparam logic [REQ_W-1:0] REQ_OFF             = 4'd3;
  localparam logic [REQ_W-1:0] REQ_TOGGLE          = 4'd4;
  localparam logic [REQ_W-1:0] REQ_QUERY           = 4'd5;
  localparam logic [REQ_W-1:0] REQ_BLINK_ON        = 4'd6;
  localparam logic [REQ_W-1:0] REQ_BLINK_OFF       = 4'd7;
  localparam logic [REQ_W-1:0] REQ_BLINK_QUERY     = 4'd8;
  localparam logic [REQ_W-1:0] REQ_GLYPH           = 4'd9;
  localparam logic [REQ_W-1:0] REQ_DIGIT_BLINK_ON  = 4'd10;
  localparam logic [REQ_W-1:0] REQ_DIGIT_BLINK_OFF = 4'd11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_NORMAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_SLOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_NORMAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_SLOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_GLYPH   = 3'd5;

  // Register reset values
  localparam logic [TIME_W-1:0]   BRIGHT_NORMAL_RST = 15'd1000;
  localparam logic [TIME_W-1:0]   BRIGHT_SLOW_RST   = 15'd2000;
  localparam logic [TIME_W-1:0]   DARK_NORMAL_RST   = 15'd1000;
  localparam logic [TIME_W-1:0]   DARK_SLOW_RST     = 15'd6000;
  localparam logic [OFFSET_W-1:0] START_OFFSET_RST  = 14'd447;
  localparam logic [GIDX_W-1:0]   ERROR_GLYPH_RST   = 5'd17;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 16'h7FFF;

  // Seven-segment glyphs, segment a in bit 0
  localparam int GLYPH_COUNT = 29;
  localparam logic [GIDX_W-1:0] GLYPH_LAST = 5'd28;
  localparam logic [FIELD_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [FIELD_W-1:0] ASCII_NINE = 8'd57;
  localparam logic [6:0] GLYPH_TABLE [GLYPH_COUNT] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
    7'h00, 7'h49, 7'h36, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h76,
    7'h38, 7'h5C, 7'h73, 7'h50, 7'h3E, 7'h1C, 7'h40, 7'h63, 7'h58
  };

  // Map a character code to its segment pattern; unknown codes take the
  // error glyph, clamped to the last table entry.
  function automatic logic [6:0] glyph_bits(input logic [FIELD_W-1:0] code,
                                            input logic [GIDX_W-1:0] err_idx);
    logic [GIDX_W-1:0]  idx;
    logic [FIELD_W-1:0] digit;
    digit = code - ASCII_ZERO;
    if (code < FIELD_W'(GLYPH_COUNT)) begin
      idx = code[GIDX_W-1:0];
    end else if (code >= ASCII_ZERO && code <= ASCII_NINE) begin
      idx = digit[GIDX_W-1:0];
    end else if (err_idx > GLYPH_LAST) begin
      idx = GLYPH_LAST;
    end else begin
      idx = err_idx;
    end
    return GLYPH_TABLE[idx];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lmbc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module lmbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hw/rtl/led_matrix_blink_controller_core.sv]
// Top level of the LED matrix blink controller: command decode, image and
// blink memories (lmbc_ram), blink phase timers. Depends on lmbc_pkg.
//
// Usage:
//   Commands enter on the in_ stream (in_tuser = request code, in_tdata =
//   row, column, class, character, point). Every command returns exactly one
//   item on the out_ stream: out_tuser = error status, out_tdata = query bit,
//   masked row pixels and one-hot row select (zero unless a valid scan).
//   The image and the per-class blink masks live in two synchronous RAMs,
//   one row per entry; the blink RAM row holds all classes side by side.
//   The read is issued in the accept cycle; in the execute state the row is
//   modified and written back, and the result registered, once the output
//   register can take it. A new item is accepted only after the last one has
//   finished its read-modify-write on the row RAMs; the write lands before
//   the next read, so no forwarding is needed.
//   A stalled receiver holds the result in the output register; one further
//   item is accepted and then waits, with its write-back held, until the
//   output register frees up.
//   Reset (rst_n low, synchronous) restores the register defaults, clears the
//   per-row valid bits so every row reads as zero, sets all classes dark
//   with a bright interval pending, and reloads the timers. No clearing pass.
//   Configuration is taken at any cycle with cfg_wr_en high; writing the
//   start offset also reloads all class timers.
`default_nettype none

module led_matrix_blink_controller_core
  import lmbc_pkg::*;
#(
  parameter int ROW_COUNT   = ROW_COUNT_DEF,
  parameter int COL_COUNT   = COL_COUNT_DEF,
  parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Command stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // row_index[7:0], col_index[15:8],
                                                // speed_class[23:16], char_code[31:24],
                                                // point_flag[32], zero pad
  input  wire logic [REQ_W-1:0]      in_tuser,  // req_type[3:0]
  // Result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata, // query_bit[0], row_pixels[32:1],
                                                // row_select[40:33], zero pad
  output logic                       out_tuser, // status[0]
  // Configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int CW = $clog2(COL_COUNT);
  localparam int BW = CLASS_COUNT * COL_COUNT;

  typedef logic [COL_COUNT-1:0] row_t;
  typedef logic [BW-1:0]        blk_row_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // Configuration registers; the start offset only acts at the write itself,
  // where it reloads the timers straight from the write data
  logic [TIME_W-1:0]   bright_normal_r, bright_slow_r, dark_normal_r, dark_slow_r;
  logic [GIDX_W-1:0]   error_glyph_r;

  // Control and latched command
  state_t             state_r, state_nxt;
  logic [REQ_W-1:0]   req_r;
  logic [FIELD_W-1:0] row_r, col_r, cls_r, chr_r;
  logic               pt_r;
  logic               img_rd_vld_r, blk_rd_vld_r;
  logic [ROW_COUNT-1:0] img_vld_r, blk_vld_r, blk_nz_r;

  // Blink timers
  logic [ELAPSED_W-1:0] elapsed_r [CLASS_COUNT];
  logic [ELAPSED_W-1:0] elapsed_nxt [CLASS_COUNT];
  logic [CLASS_COUNT-1:0] dark_r, ivl_dark_r, dark_nxt, ivl_dark_nxt;

  // Output register
  logic              out_valid_r, out_status_r, out_query_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic [SEL_W-1:0]  out_sel_r;

  // Input field views
  logic [FIELD_W-1:0] in_row;
  logic               in_row_ok, in_accept;
  logic [RW-1:0]      in_addr, addr;

  // Memory read data and write control
  row_t     img_rdata, img_q, img_new;
  blk_row_t blk_rdata, blk_q, blk_new;
  logic     img_we, blk_we;

  // Execute stage
  logic       go, row_ok, rc_ok, dig_ok, cls_ok, is_tick, any_blink;
  logic       status, qbit;
  row_t       pix, col_bit, dig_ff, dig_mask, dig_val;
  logic [SEL_W-1:0] sel;
  logic [6:0] glyph;

  assign in_row    = in_tdata[FIELD_W-1:0];
  assign in_row_ok = in_row < FIELD_W'(ROW_COUNT);
  assign in_addr   = in_row[RW-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign addr      = row_r[RW-1:0];

  // Finish the item only when the output register can take its result
  assign go = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  lmbc_ram #(.WIDTH(COL_COUNT), .DEPTH(ROW_COUNT)) u_img_ram (
    .clk     (clk),
    .wr_en   (img_we && go),
    .wr_addr (addr),
    .wr_data (img_new),
    .rd_en   (in_accept),
    .rd_addr (in_addr),
    .rd_data (img_rdata)
  );

  lmbc_ram #(.WIDTH(BW), .DEPTH(ROW_COUNT)) u_blk_ram (
    .clk     (clk),
    .wr_en   (blk_we && go),
    .wr_addr (addr),
    .wr_data (blk_new),
    .rd_en   (in_accept),
    .rd_addr (in_addr),
    .rd_data (blk_rdata)
  );

  // Rows never written read as zero
  assign img_q = img_rd_vld_r ? img_rdata : '0;
  assign blk_q = blk_rd_vld_r ? blk_rdata : '0;

  // Address checks on the latched command
  assign row_ok = row_r < FIELD_W'(ROW_COUNT);
  assign rc_ok  = row_ok && (col_r < FIELD_W'(COL_COUNT));
  assign dig_ok = row_ok && (({1'b0, col_r} + 9'd7) < 9'(COL_COUNT));
  assign cls_ok = cls_r < FIELD_W'(CLASS_COUNT);

  assign col_bit  = rc_ok ? (row_t'(1) << col_r[CW-1:0]) : '0;
  assign glyph    = glyph_bits(chr_r, error_glyph_r);
  assign dig_ff   = row_t'(8'hFF) << col_r[CW-1:0];
  assign dig_val  = row_t'({pt_r, glyph}) << col_r[CW-1:0];
  assign dig_mask = row_t'({pt_r, 7'h7F}) << col_r[CW-1:0];

  assign any_blink = |blk_nz_r;

  // Command decode and row modify
  always_comb begin
    status  = 1'b0;
    qbit    = 1'b0;
    pix     = '0;
    sel     = '0;
    img_we  = 1'b0;
    blk_we  = 1'b0;
    img_new = img_q;
    blk_new = blk_q;
    is_tick = 1'b0;
    case (req_r)
      REQ_TICK: begin
        is_tick = 1'b1;
      end
      REQ_SCAN: begin
        if (!row_ok) begin
          status = 1'b1;
        end else begin
          pix = img_q;
          for (int k = 0; k < CLASS_COUNT; k++) begin
            if (dark_r[k]) begin
              pix = pix & ~blk_q[k*COL_COUNT +: COL_COUNT];
            end
          end
          sel = SEL_W'(1) << addr;
        end
      end
      REQ_ON, REQ_OFF, REQ_TOGGLE, REQ_QUERY: begin
        if (!rc_ok) begin
          status = 1'b1;
        end else if (req_r == REQ_QUERY) begin
          qbit = |(img_q & col_bit);
        end else begin
          img_we = 1'b1;
          if (req_r == REQ_ON) begin
            img_new = img_q | col_bit;
          end else if (req_r == REQ_OFF) begin
            img_new = img_q & ~col_bit;
          end else begin
            img_new = img_q ^ col_bit;
          end
        end
      end
      REQ_BLINK_ON, REQ_BLINK_OFF, REQ_BLINK_QUERY: begin
        if (!rc_ok || !cls_ok) begin
          status = 1'b1;
        end else begin
          blk_we = (req_r != REQ_BLINK_QUERY);
          for (int k = 0; k < CLASS_COUNT; k++) begin
            if (cls_r == FIELD_W'(k)) begin
              qbit = |(blk_q[k*COL_COUNT +: COL_COUNT] & col_bit);
              if (req_r == REQ_BLINK_ON) begin
                blk_new[k*COL_COUNT +: COL_COUNT] =
                  blk_q[k*COL_COUNT +: COL_COUNT] | col_bit;
              end else begin
                blk_new[k*COL_COUNT +: COL_COUNT] =
                  blk_q[k*COL_COUNT +: COL_COUNT] & ~col_bit;
              end
            end
          end
          if (req_r != REQ_BLINK_QUERY) begin
            qbit = 1'b0;
          end
        end
      end
      REQ_GLYPH: begin
        if (!dig_ok) begin
          status = 1'b1;
        end else begin
          img_we  = 1'b1;
          img_new = (img_q & ~dig_ff) | dig_val;
        end
      end
      REQ_DIGIT_BLINK_ON, REQ_DIGIT_BLINK_OFF: begin
        if (!dig_ok || !cls_ok) begin
          status = 1'b1;
        end else begin
          blk_we = 1'b1;
          for (int k = 0; k < CLASS_COUNT; k++) begin
            if (cls_r == FIELD_W'(k)) begin
              if (req_r == REQ_DIGIT_BLINK_ON) begin
                blk_new[k*COL_COUNT +: COL_COUNT] =
                  blk_q[k*COL_COUNT +: COL_COUNT] | dig_mask;
              end else begin
                blk_new[k*COL_COUNT +: COL_COUNT] =
                  blk_q[k*COL_COUNT +: COL_COUNT] & ~dig_mask;
              end
            end
          end
        end
      end
      default: begin
        status = 1'b1;
      end
    endcase
  end

  // Blink timers: reload on an offset write, advance on a tick
  always_comb begin
    logic [ELAPSED_W-1:0] e;
    logic [TIME_W-1:0]    iv;
    for (int k = 0; k < CLASS_COUNT; k++) begin
      elapsed_nxt[k]  = elapsed_r[k];
      dark_nxt[k]     = dark_r[k];
      ivl_dark_nxt[k] = ivl_dark_r[k];
      e  = elapsed_r[k];
      if (k == 0) begin
        iv = ivl_dark_r[k] ? dark_normal_r : bright_normal_r;
      end else begin
        iv = ivl_dark_r[k] ? dark_slow_r : bright_slow_r;
      end
      if (cfg_wr_en && (cfg_index == CFG_START_OFFSET)) begin
        elapsed_nxt[k] = ELAPSED_W'(-(k * int'(cfg_wdata[OFFSET_W-1:0])));
      end else if (go && is_tick) begin
        if (e != ELAPSED_MAX) begin
          e = e + 1'b1;
        end
        if (any_blink && ($signed({e[ELAPSED_W-1], e}) > $signed({2'b00, iv}))) begin
          ivl_dark_nxt[k] = !dark_r[k];
          dark_nxt[k]     = !dark_r[k];
          e               = '0;
        end
        elapsed_nxt[k] = e;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      img_vld_r   <= '0;
      blk_vld_r   <= '0;
      blk_nz_r    <= '0;
      dark_r      <= '1;
      ivl_dark_r  <= '0;
      for (int k = 0; k < CLASS_COUNT; k++) begin
        elapsed_r[k] <= ELAPSED_W'(-(k * int'(START_OFFSET_RST)));
      end
      bright_normal_r <= BRIGHT_NORMAL_RST;
      bright_slow_r   <= BRIGHT_SLOW_RST;
      dark_normal_r   <= DARK_NORMAL_RST;
      dark_slow_r     <= DARK_SLOW_RST;
      error_glyph_r   <= ERROR_GLYPH_RST;
    end else begin
      state_r    <= state_nxt;
      dark_r     <= dark_nxt;
      ivl_dark_r <= ivl_dark_nxt;
      for (int k = 0; k < CLASS_COUNT; k++) begin
        elapsed_r[k] <= elapsed_nxt[k];
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (go && img_we) begin
        img_vld_r[addr] <= 1'b1;
      end
      if (go && blk_we) begin
        blk_vld_r[addr] <= 1'b1;
        blk_nz_r[addr]  <= |blk_new;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BRIGHT_NORMAL: bright_normal_r <= cfg_wdata[TIME_W-1:0];
          CFG_BRIGHT_SLOW:   bright_slow_r   <= cfg_wdata[TIME_W-1:0];
          CFG_DARK_NORMAL:   dark_normal_r   <= cfg_wdata[TIME_W-1:0];
          CFG_DARK_SLOW:     dark_slow_r     <= cfg_wdata[TIME_W-1:0];
          CFG_ERROR_GLYPH:   error_glyph_r   <= cfg_wdata[GIDX_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload: latch the command and the row valid bits at accept, and the result fields when the item finishes
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r        <= in_tuser;
      row_r        <= in_row;
      col_r        <= in_tdata[2*FIELD_W-1:FIELD_W];
      cls_r        <= in_tdata[3*FIELD_W-1:2*FIELD_W];
      chr_r        <= in_tdata[4*FIELD_W-1:3*FIELD_W];
      pt_r         <= in_tdata[4*FIELD_W];
      img_rd_vld_r <= in_row_ok && img_vld_r[in_addr];
      blk_rd_vld_r <= in_row_ok && blk_vld_r[in_addr];
    end
    if (go) begin
      out_status_r <= status;
      out_query_r  <= qbit;
      out_pix_r    <= PIX_W'(pix);
      out_sel_r    <= sel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DATA_W'({out_sel_r, out_pix_r, out_query_r});

  // An accepted item always moves into the execute state
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_EXEC))
    else $error("accepted item did not enter execute");

  // A finished item always shows up as a valid result
  a_go_out: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("finished item lost before output register");

  // No RAM write-back in the cycle a new read is issued
  a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_accept && go))
    else $error("read issued during write-back");

  // Row select is zero or one-hot
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_sel_r))
    else $error("row select not one-hot");

endmodule

`default_nettype wire
